// File: sv/rdmc_pkg.sv
package rdmc_pkg;

    // Field and register widths
    localparam int SIDE_REG_W = 6;
    localparam int WALL_W     = 7;
    localparam int NEXT_W     = 3;
    localparam int EPOCH_W    = 8;

    // Request commands
    localparam logic CMD_START    = 1'b0;
    localparam logic CMD_CONTINUE = 1'b1;

    // Configuration register indexes
    localparam logic REG_CELL_ROWS = 1'b0;
    localparam logic REG_CELL_COLS = 1'b1;

    // Largest legal swap partner for order position 2
    localparam logic [1:0] DRAW_THREE_MAX = 2'd2;

    // Number of directions tried per cell
    localparam logic [NEXT_W-1:0] DIR_COUNT = 3'd4;

    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_RIGHT = 2'd3
    } dir_t;

    typedef dir_t [3:0] order_t;

    localparam order_t ORDER_INIT = {DIR_RIGHT, DIR_LEFT, DIR_DOWN, DIR_UP};

    // Datapath operation of one control word
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_ACCEPT,
        OP_START,
        OP_SHUFFLE,
        OP_PROBE,
        OP_CARVE,
        OP_POP,
        OP_LOAD,
        OP_FINISH
    } op_t;

    // Jump condition of one control word
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_CLR_BUSY,
        C_NO_REQ,
        C_CONT,
        C_EPOCH_ROOM,
        C_DIR_DONE,
        C_BLOCKED,
        C_OUT_BUSY,
        C_LAST_FRAME,
        C_WALK
    } cond_t;

    // Program steps
    typedef enum logic [3:0] {
        ST_CLEAR      = 4'd0,
        ST_IDLE       = 4'd1,
        ST_DISPATCH   = 4'd2,
        ST_EPOCH_CHK  = 4'd3,
        ST_WRAP_CLEAR = 4'd4,
        ST_START      = 4'd5,
        ST_SHUFFLE    = 4'd6,
        ST_PROBE      = 4'd7,
        ST_TEST       = 4'd8,
        ST_CARVE_WAIT = 4'd9,
        ST_CARVE      = 4'd10,
        ST_POP        = 4'd11,
        ST_LOAD       = 4'd12,
        ST_CHK_WALK   = 4'd13,
        ST_FIN_WAIT   = 4'd14,
        ST_FINISH     = 4'd15
    } step_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ucode_t;

    // Control store: jump to target when cond holds, else fall through
    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        case (step)
            ST_CLEAR:      w = '{OP_CLEAR,   C_CLR_BUSY,   ST_CLEAR};
            ST_IDLE:       w = '{OP_ACCEPT,  C_NO_REQ,     ST_IDLE};
            ST_DISPATCH:   w = '{OP_NONE,    C_CONT,       ST_CHK_WALK};
            ST_EPOCH_CHK:  w = '{OP_NONE,    C_EPOCH_ROOM, ST_START};
            ST_WRAP_CLEAR: w = '{OP_CLEAR,   C_CLR_BUSY,   ST_WRAP_CLEAR};
            ST_START:      w = '{OP_START,   C_NEVER,      ST_START};
            ST_SHUFFLE:    w = '{OP_SHUFFLE, C_NEVER,      ST_SHUFFLE};
            ST_PROBE:      w = '{OP_PROBE,   C_DIR_DONE,   ST_POP};
            ST_TEST:       w = '{OP_NONE,    C_BLOCKED,    ST_PROBE};
            ST_CARVE_WAIT: w = '{OP_NONE,    C_OUT_BUSY,   ST_CARVE_WAIT};
            ST_CARVE:      w = '{OP_CARVE,   C_ALWAYS,     ST_IDLE};
            ST_POP:        w = '{OP_POP,     C_LAST_FRAME, ST_FIN_WAIT};
            ST_LOAD:       w = '{OP_LOAD,    C_ALWAYS,     ST_PROBE};
            ST_CHK_WALK:   w = '{OP_NONE,    C_WALK,       ST_SHUFFLE};
            ST_FIN_WAIT:   w = '{OP_NONE,    C_OUT_BUSY,   ST_FIN_WAIT};
            ST_FINISH:     w = '{OP_FINISH,  C_ALWAYS,     ST_IDLE};
            default:       w = '{OP_NONE,    C_ALWAYS,     ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

// File: sv/rdmc_ifs.sv
// Request channel: one walk step
interface rdmc_req_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [1:0] draw_four;
    logic [1:0] draw_three;
    logic       draw_two;

    modport source (output valid, output command, output draw_four,
                    output draw_three, output draw_two, input ready);
    modport sink   (input valid, input command, input draw_four,
                    input draw_three, input draw_two, output ready);
endinterface

// Result channel: one carve report
interface rdmc_res_if;
    logic                          valid;
    logic                          ready;
    logic                          carved;
    logic [rdmc_pkg::WALL_W-1:0]   wall_row;
    logic [rdmc_pkg::WALL_W-1:0]   wall_col;
    logic                          last;

    modport source (output valid, output carved, output wall_row,
                    output wall_col, output last, input ready);
    modport sink   (input valid, input carved, input wall_row,
                    input wall_col, input last, output ready);
endinterface

// Configuration write channel
interface rdmc_cfg_if;
    logic                              valid;
    logic                              ready;
    logic                              index;
    logic [rdmc_pkg::SIDE_REG_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/rdmc_ram.sv
module rdmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/random_dfs_maze_carver_unit.sv
// Channel   Dir  Payload                                   Accepted when
// cfg       in   index (1), data (6)                       cfg.valid & cfg.ready
// request   in   command, draw_four, draw_three, draw_two  request.valid & request.ready
// result    out  carved, wall_row (7), wall_col (7), last  result.valid & result.ready
//
// One request at a time: each direction probed waits for a visited-map read, each stack
// frame popped for a stack read, and the result is posted through the output register.
// After reset a clearing pass over all MAX_SIDE_CELLS^2 cells runs before the first request;
// the same pass repeats at the 256th start and every 255th after, when the epoch wraps.
// A stalled result holds in the output register; the next request may be taken meanwhile.
// cfg is always ready and may be written at any time, also during a clearing pass.
module random_dfs_maze_carver_unit #(
    parameter int MAX_SIDE_CELLS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    rdmc_cfg_if.sink    cfg,
    rdmc_req_if.sink    request,
    rdmc_res_if.source  result
);

    localparam int CELL_COUNT = MAX_SIDE_CELLS * MAX_SIDE_CELLS;
    localparam int AW         = $clog2(CELL_COUNT);
    localparam int DW         = $clog2(CELL_COUNT + 1);
    localparam int CW         = $clog2(MAX_SIDE_CELLS);
    localparam int SW         = CW + 1;
    localparam int OW         = $bits(rdmc_pkg::order_t);
    localparam int FW         = 2 * CW + OW + rdmc_pkg::NEXT_W;
    localparam int EW         = rdmc_pkg::EPOCH_W;
    localparam int RW         = rdmc_pkg::SIDE_REG_W;
    localparam int WW         = rdmc_pkg::WALL_W;

    // Clamp a size register to 1..MAX_SIDE_CELLS
    function automatic logic [SW-1:0] clamp_side(input logic [RW-1:0] v);
        logic [SW-1:0] r;
        if (v == '0)
        begin
            r = SW'(1);
        end
        else if (32'(v) > MAX_SIDE_CELLS)
        begin
            r = SW'(MAX_SIDE_CELLS);
        end
        else
        begin
            r = SW'(v);
        end
        return r;
    endfunction

    function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] r,
                                                input logic [CW-1:0] c);
        return AW'(32'(r) * 32'(MAX_SIDE_CELLS) + 32'(c));
    endfunction

    // Sequencer and control state
    rdmc_pkg::step_t          upc_reg, upc_next;
    rdmc_pkg::ucode_t         uc;
    logic                     jump;
    logic [AW-1:0]            clr_cnt_reg, clr_cnt_next;
    logic [EW-1:0]            epoch_reg, epoch_next;
    logic [DW-1:0]            depth_reg, depth_next;
    logic                     active_reg, active_next;
    logic                     out_valid_reg, out_valid_next;
    logic [RW-1:0]            cell_rows_reg, cell_cols_reg;

    // Payload state
    logic                     cmd_reg, cmd_next;
    logic [1:0]               d4_reg, d4_next;
    logic [1:0]               d3_reg, d3_next;
    logic                     d2_reg, d2_next;
    logic [CW-1:0]            top_row_reg, top_row_next;
    logic [CW-1:0]            top_col_reg, top_col_next;
    rdmc_pkg::order_t         top_order_reg, top_order_next;
    logic [rdmc_pkg::NEXT_W-1:0] top_next_reg, top_next_next;
    logic [CW-1:0]            nb_row_reg, nb_row_next;
    logic [CW-1:0]            nb_col_reg, nb_col_next;
    logic                     nb_ok_reg, nb_ok_next;
    rdmc_pkg::dir_t           dir_reg, dir_next;
    logic                     carved_reg, carved_next;
    logic [WW-1:0]            wall_row_reg, wall_row_next;
    logic [WW-1:0]            wall_col_reg, wall_col_next;
    logic                     last_reg, last_next;

    // Datapath signals
    logic [SW-1:0]            rows_eff, cols_eff;
    logic [SW-1:0]            row_inc, col_inc;
    logic                     row_in, col_in;
    rdmc_pkg::dir_t           dir_cur;
    logic [CW-1:0]            probe_row, probe_col;
    logic                     probe_ok;
    logic                     dir_done;
    logic                     out_busy;
    rdmc_pkg::order_t         shuf_a, shuf_b, shuf_c;
    logic [1:0]               d3_sat;
    logic [CW+1:0]            row_x2, col_x2;

    logic                     vis_we;
    logic [AW-1:0]            vis_waddr;
    logic [EW-1:0]            vis_wdata;
    logic [EW-1:0]            vis_rdata;
    logic                     stk_we;
    logic [AW-1:0]            stk_raddr;
    logic [FW-1:0]            stk_wdata;
    logic [FW-1:0]            stk_rdata;

    assign uc       = rdmc_pkg::ucode_rom(upc_reg);
    assign rows_eff = clamp_side(cell_rows_reg);
    assign cols_eff = clamp_side(cell_cols_reg);
    assign out_busy = out_valid_reg && !result.ready;
    assign dir_done = (top_next_reg == rdmc_pkg::DIR_COUNT);

    // Neighbor of the top cell in its next direction
    assign dir_cur = top_order_reg[top_next_reg[1:0]];
    assign row_inc = {1'b0, top_row_reg} + SW'(1);
    assign col_inc = {1'b0, top_col_reg} + SW'(1);
    assign row_in  = ({1'b0, top_row_reg} < rows_eff);
    assign col_in  = ({1'b0, top_col_reg} < cols_eff);

    // Both neighbor coordinates must lie inside the grid in use
    always_comb
    begin
        probe_row = top_row_reg;
        probe_col = top_col_reg;
        probe_ok  = 1'b0;
        case (dir_cur)
            rdmc_pkg::DIR_UP:
            begin
                probe_row = top_row_reg - CW'(1);
                probe_ok  = (top_row_reg != '0) && ({1'b0, probe_row} < rows_eff) && col_in;
            end
            rdmc_pkg::DIR_DOWN:
            begin
                probe_row = row_inc[CW-1:0];
                probe_ok  = (row_inc < rows_eff) && col_in;
            end
            rdmc_pkg::DIR_LEFT:
            begin
                probe_col = top_col_reg - CW'(1);
                probe_ok  = (top_col_reg != '0) && ({1'b0, probe_col} < cols_eff) && row_in;
            end
            rdmc_pkg::DIR_RIGHT:
            begin
                probe_col = col_inc[CW-1:0];
                probe_ok  = (col_inc < cols_eff) && row_in;
            end
            default:
            begin
                probe_ok = 1'b0;
            end
        endcase
    end

    // Shuffle the top cell's direction order with the three draws
    assign d3_sat = (d3_reg > rdmc_pkg::DRAW_THREE_MAX) ? rdmc_pkg::DRAW_THREE_MAX : d3_reg;

    always_comb
    begin
        shuf_a            = top_order_reg;
        shuf_a[3]         = top_order_reg[d4_reg];
        shuf_a[d4_reg]    = top_order_reg[3];
        shuf_b            = shuf_a;
        shuf_b[2]         = shuf_a[d3_sat];
        shuf_b[d3_sat]    = shuf_a[2];
        shuf_c            = shuf_b;
        shuf_c[1]         = shuf_b[{1'b0, d2_reg}];
        shuf_c[{1'b0, d2_reg}] = shuf_b[1];
    end

    // Wall coordinates: twice the cell plus the direction offset
    assign row_x2 = {1'b0, top_row_reg, 1'b0};
    assign col_x2 = {1'b0, top_col_reg, 1'b0};

    // Jump condition
    always_comb
    begin
        case (uc.cond)
            rdmc_pkg::C_NEVER:      jump = 1'b0;
            rdmc_pkg::C_ALWAYS:     jump = 1'b1;
            rdmc_pkg::C_CLR_BUSY:   jump = (32'(clr_cnt_reg) != CELL_COUNT - 1);
            rdmc_pkg::C_NO_REQ:     jump = !request.valid;
            rdmc_pkg::C_CONT:       jump = (cmd_reg == rdmc_pkg::CMD_CONTINUE);
            rdmc_pkg::C_EPOCH_ROOM: jump = (epoch_reg != '1);
            rdmc_pkg::C_DIR_DONE:   jump = dir_done;
            rdmc_pkg::C_BLOCKED:    jump = !nb_ok_reg || (vis_rdata == epoch_reg);
            rdmc_pkg::C_OUT_BUSY:   jump = out_busy;
            rdmc_pkg::C_LAST_FRAME: jump = (depth_reg == DW'(1));
            rdmc_pkg::C_WALK:       jump = active_reg && (depth_reg != '0);
            default:                jump = 1'b0;
        endcase
    end

    // Execute the current control word
    always_comb
    begin
        upc_next       = jump ? uc.target : rdmc_pkg::step_t'(upc_reg + 4'd1);
        clr_cnt_next   = clr_cnt_reg;
        epoch_next     = epoch_reg;
        depth_next     = depth_reg;
        active_next    = active_reg;
        out_valid_next = out_valid_reg && !result.ready;
        cmd_next       = cmd_reg;
        d4_next        = d4_reg;
        d3_next        = d3_reg;
        d2_next        = d2_reg;
        top_row_next   = top_row_reg;
        top_col_next   = top_col_reg;
        top_order_next = top_order_reg;
        top_next_next  = top_next_reg;
        nb_row_next    = nb_row_reg;
        nb_col_next    = nb_col_reg;
        nb_ok_next     = nb_ok_reg;
        dir_next       = dir_reg;
        carved_next    = carved_reg;
        wall_row_next  = wall_row_reg;
        wall_col_next  = wall_col_reg;
        last_next      = last_reg;
        vis_we         = 1'b0;
        vis_waddr      = clr_cnt_reg;
        vis_wdata      = '0;
        stk_we         = 1'b0;
        stk_raddr      = AW'(depth_reg - DW'(2));
        stk_wdata      = {top_row_reg, top_col_reg, top_order_reg, top_next_reg};

        case (uc.op)
            rdmc_pkg::OP_CLEAR:
            begin
                vis_we = 1'b1;
                if (32'(clr_cnt_reg) == CELL_COUNT - 1)
                begin
                    clr_cnt_next = '0;
                    epoch_next   = '0;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + AW'(1);
                end
            end
            rdmc_pkg::OP_ACCEPT:
            begin
                if (request.valid)
                begin
                    cmd_next = request.command;
                    d4_next  = request.draw_four;
                    d3_next  = request.draw_three;
                    d2_next  = request.draw_two;
                end
            end
            rdmc_pkg::OP_START:
            begin
                epoch_next     = epoch_reg + EW'(1);
                vis_we         = 1'b1;
                vis_waddr      = '0;
                vis_wdata      = epoch_reg + EW'(1);
                top_row_next   = '0;
                top_col_next   = '0;
                top_order_next = rdmc_pkg::ORDER_INIT;
                top_next_next  = '0;
                depth_next     = DW'(1);
                active_next    = 1'b1;
            end
            rdmc_pkg::OP_SHUFFLE:
            begin
                top_order_next = shuf_c;
            end
            rdmc_pkg::OP_PROBE:
            begin
                if (!dir_done)
                begin
                    nb_row_next   = probe_row;
                    nb_col_next   = probe_col;
                    nb_ok_next    = probe_ok;
                    dir_next      = dir_cur;
                    top_next_next = top_next_reg + rdmc_pkg::NEXT_W'(1);
                end
            end
            rdmc_pkg::OP_CARVE:
            begin
                out_valid_next = 1'b1;
                carved_next    = 1'b1;
                last_next      = 1'b0;
                case (dir_reg)
                    rdmc_pkg::DIR_UP:
                    begin
                        wall_row_next = WW'(row_x2);
                        wall_col_next = WW'(col_x2 + (CW+2)'(1));
                    end
                    rdmc_pkg::DIR_DOWN:
                    begin
                        wall_row_next = WW'(row_x2 + (CW+2)'(2));
                        wall_col_next = WW'(col_x2 + (CW+2)'(1));
                    end
                    rdmc_pkg::DIR_LEFT:
                    begin
                        wall_row_next = WW'(row_x2 + (CW+2)'(1));
                        wall_col_next = WW'(col_x2);
                    end
                    default:
                    begin
                        wall_row_next = WW'(row_x2 + (CW+2)'(1));
                        wall_col_next = WW'(col_x2 + (CW+2)'(2));
                    end
                endcase
                // Push the current frame, then make the neighbor the top
                stk_we         = 1'b1;
                vis_we         = 1'b1;
                vis_waddr      = cell_addr(nb_row_reg, nb_col_reg);
                vis_wdata      = epoch_reg;
                top_row_next   = nb_row_reg;
                top_col_next   = nb_col_reg;
                top_order_next = rdmc_pkg::ORDER_INIT;
                top_next_next  = '0;
                depth_next     = depth_reg + DW'(1);
            end
            rdmc_pkg::OP_POP:
            begin
                depth_next = depth_reg - DW'(1);
            end
            rdmc_pkg::OP_LOAD:
            begin
                {top_row_next, top_col_next, top_order_next, top_next_next} = stk_rdata;
            end
            rdmc_pkg::OP_FINISH:
            begin
                out_valid_next = 1'b1;
                carved_next    = 1'b0;
                wall_row_next  = '0;
                wall_col_next  = '0;
                last_next      = 1'b1;
                active_next    = 1'b0;
            end
            default:
            begin
                vis_we = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= rdmc_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            epoch_reg     <= '0;
            depth_reg     <= '0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            upc_reg       <= upc_next;
            clr_cnt_reg   <= clr_cnt_next;
            epoch_reg     <= epoch_next;
            depth_reg     <= depth_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_rows_reg <= RW'(1);
            cell_cols_reg <= RW'(1);
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                rdmc_pkg::REG_CELL_ROWS: cell_rows_reg <= cfg.data;
                rdmc_pkg::REG_CELL_COLS: cell_cols_reg <= cfg.data;
                default:                 cell_rows_reg <= cell_rows_reg;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        d4_reg        <= d4_next;
        d3_reg        <= d3_next;
        d2_reg        <= d2_next;
        top_row_reg   <= top_row_next;
        top_col_reg   <= top_col_next;
        top_order_reg <= top_order_next;
        top_next_reg  <= top_next_next;
        nb_row_reg    <= nb_row_next;
        nb_col_reg    <= nb_col_next;
        nb_ok_reg     <= nb_ok_next;
        dir_reg       <= dir_next;
        carved_reg    <= carved_next;
        wall_row_reg  <= wall_row_next;
        wall_col_reg  <= wall_col_next;
        last_reg      <= last_next;
    end

    // Visited map: epoch mark per cell
    rdmc_ram #(
        .WIDTH (EW),
        .DEPTH (CELL_COUNT)
    ) u_visited (
        .clk   (clk),
        .we    (vis_we),
        .waddr (vis_waddr),
        .wdata (vis_wdata),
        .raddr (cell_addr(probe_row, probe_col)),
        .rdata (vis_rdata)
    );

    // Walk stack: frames below the top
    rdmc_ram #(
        .WIDTH (FW),
        .DEPTH (CELL_COUNT)
    ) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (AW'(depth_reg - DW'(1))),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // Ports
    assign cfg.ready       = 1'b1;
    assign request.ready   = (upc_reg == rdmc_pkg::ST_IDLE);
    assign result.valid    = out_valid_reg;
    assign result.carved   = carved_reg;
    assign result.wall_row = wall_row_reg;
    assign result.wall_col = wall_col_reg;
    assign result.last     = last_reg;

endmodule

// File: sv/rdmc_checker.sv
module rdmc_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic                        res_valid,
    input logic                        res_ready,
    input logic                        carved,
    input logic [rdmc_pkg::WALL_W-1:0] wall_row,
    input logic [rdmc_pkg::WALL_W-1:0] wall_col,
    input logic                        last
);

    // Hold a stalled result
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    // A carve is never also the end of the walk
    a_carve_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(carved && last))
        else $error("carved and last both set");

    // No carve means no wall coordinates
    a_no_carve_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !carved |-> (wall_row == '0) && (wall_col == '0))
        else $error("wall coordinates set without a carve");

    // A result never rises in the cycle after its request is taken
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !$rose(res_valid))
        else $error("result raised right after request");

endmodule

bind random_dfs_maze_carver_unit rdmc_checker u_rdmc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (request.valid),
    .req_ready (request.ready),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .carved    (result.carved),
    .wall_row  (result.wall_row),
    .wall_col  (result.wall_col),
    .last      (result.last)
);
